// ===== src/irpq_pkg.sv =====
// Shared types and codes for the interrupt request priority queue.
`default_nettype none

package irpq_pkg;

    localparam int TABLE_DEPTH_DEF = 8;

    localparam logic OP_RAISE = 1'b0;
    localparam logic OP_TAKE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_VEC   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_TAKE_NONE = 2'd3;

    typedef struct packed {
        logic       op;
        logic [7:0] req_vector;
        logic [7:0] req_priority;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] taken_vector;
        logic [7:0] taken_priority;
        logic       lowest_dropped;
        logic       now_empty;
    } t_out_word;

    // per-cell update command
    typedef struct packed {
        logic raise;
        logic take;
        logic ins;
        logic shift_in;
    } t_cell_cmd;

    // per-cell search flags against the pending request
    typedef struct packed {
        logic lower_pri;
        logic vec_at_least;
    } t_cell_flag;

endpackage

`default_nettype wire

// ===== src/irpq_cell.sv =====
// One table slot: holds a vector and priority, compares against the request, shifts.
`default_nettype none

module irpq_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire irpq_pkg::t_cell_cmd   i_cmd,
    input  wire logic [7:0]            i_new_vec,
    input  wire logic [7:0]            i_new_pri,
    input  wire logic [7:0]            i_prev_vec,
    input  wire logic [7:0]            i_prev_pri,
    input  wire logic [7:0]            i_next_vec,
    input  wire logic [7:0]            i_next_pri,
    output logic [7:0]                 o_vec,
    output logic [7:0]                 o_pri,
    output irpq_pkg::t_cell_flag       o_flag
);
    import irpq_pkg::*;

    logic [7:0] r_vec;
    logic [7:0] r_pri;
    logic [7:0] n_vec;
    logic [7:0] n_pri;
    logic       w_empty;

    assign w_empty = (r_vec == 8'd0);

    always_comb begin
        o_flag.lower_pri    = w_empty || (r_pri < i_new_pri);
        o_flag.vec_at_least = w_empty || (r_vec >= i_new_vec);
    end

    always_comb begin
        n_vec = r_vec;
        n_pri = r_pri;
        priority if (i_cmd.raise && i_cmd.ins) begin
            n_vec = i_new_vec;
            n_pri = i_new_pri;
        end else if (i_cmd.raise && i_cmd.shift_in) begin
            n_vec = i_prev_vec;
            n_pri = i_prev_pri;
        end else if (i_cmd.take) begin
            n_vec = i_next_vec;
            n_pri = i_next_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec <= 8'd0;
            r_pri <= 8'd0;
        end else begin
            r_vec <= n_vec;
            r_pri <= n_pri;
        end
    end

    assign o_vec = r_vec;
    assign o_pri = r_pri;

endmodule

`default_nettype wire

// ===== src/interrupt_request_priority_queue_core.sv =====
// Top level: sorted interrupt request table built as a chain of slot cells.
//
//  channel | direction | handshake                 | word
//  in      | input     | i_in_valid / o_in_ready   | i_in_word  (t_in_word)
//  out     | output    | o_out_valid / i_out_ready | o_out_word (t_out_word)
//
// Each word goes through three steps: accept, position search (per-cell compares
// plus a TABLE_DEPTH-bit two's-complement scan), then the table update.
// The update waits while the output register holds an untaken word.
// A new word is accepted only when the previous one has been applied.
// Synchronous active-low reset empties every slot.
`default_nettype none

module interrupt_request_priority_queue_core #(
    parameter int TABLE_DEPTH = irpq_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire irpq_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output irpq_pkg::t_out_word      o_out_word
);
    import irpq_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POS   = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    localparam logic [TABLE_DEPTH-1:0] LSB_ONE = {{(TABLE_DEPTH-1){1'b0}}, 1'b1};

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic                   r_op;
    logic [7:0]             r_vec;
    logic [7:0]             r_pri;
    logic [TABLE_DEPTH-1:0] r_c;
    logic [TABLE_DEPTH-1:0] n_c;
    logic                   r_out_valid;
    t_out_word              r_out;
    t_out_word              n_out;

    logic [7:0]             w_vec [TABLE_DEPTH];
    logic [7:0]             w_pri [TABLE_DEPTH];
    t_cell_flag             w_flag [TABLE_DEPTH];
    t_cell_cmd              w_cmd [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_a;
    logic [TABLE_DEPTH-1:0] w_b;
    logic [TABLE_DEPTH-1:0] w_mask1;
    logic [TABLE_DEPTH-1:0] w_from;
    logic [TABLE_DEPTH-1:0] w_ins;
    logic [TABLE_DEPTH-1:0] w_after;
    logic                   w_head_empty;
    logic                   w_bad;
    logic                   w_raise_ok;
    logic                   w_take_ok;
    logic                   w_go;

    genvar k;
    generate
        for (k = 0; k < TABLE_DEPTH; k++) begin : g_cell
            logic [7:0] w_pv;
            logic [7:0] w_pp;
            logic [7:0] w_nv;
            logic [7:0] w_np;

            if (k == 0) begin : g_first
                assign w_pv = 8'd0;
                assign w_pp = 8'd0;
            end else begin : g_mid
                assign w_pv = w_vec[k-1];
                assign w_pp = w_pri[k-1];
            end

            if (k == TABLE_DEPTH - 1) begin : g_last
                assign w_nv = 8'd0;
                assign w_np = 8'd0;
            end else begin : g_inner
                assign w_nv = w_vec[k+1];
                assign w_np = w_pri[k+1];
            end

            assign w_a[k] = w_flag[k].lower_pri;
            assign w_b[k] = w_flag[k].vec_at_least;

            // raise, take, ins, shift_in
            assign w_cmd[k] = {w_go && w_raise_ok, w_go && w_take_ok, w_ins[k], w_after[k]};

            irpq_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (w_cmd[k]),
                .i_new_vec  (r_vec),
                .i_new_pri  (r_pri),
                .i_prev_vec (w_pv),
                .i_prev_pri (w_pp),
                .i_next_vec (w_nv),
                .i_next_pri (w_np),
                .o_vec      (w_vec[k]),
                .o_pri      (w_pri[k]),
                .o_flag     (w_flag[k])
            );
        end
    endgenerate

    assign w_head_empty = (w_vec[0] == 8'd0);
    assign w_bad        = r_vec[0] || (r_vec == 8'd0);

    // bits at and above the first set bit of w_a, then the w_b bits there (slot 0 if table empty)
    always_comb begin
        w_mask1 = w_a | (~w_a + LSB_ONE);
        if (w_head_empty) begin
            n_c = LSB_ONE;
        end else begin
            n_c = w_b & w_mask1;
        end
    end

    always_comb begin
        w_from  = r_c | (~r_c + LSB_ONE);
        w_ins   = r_c & (~r_c + LSB_ONE);
        w_after = w_head_empty ? '0 : (w_from & ~w_ins);
    end

    assign w_raise_ok = (r_op == OP_RAISE) && !w_bad && (r_c != '0);
    assign w_take_ok  = (r_op == OP_TAKE) && !w_head_empty;
    assign w_go       = (r_state == S_APPLY) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_out.status         = ST_OK;
        n_out.taken_vector   = 8'd0;
        n_out.taken_priority = 8'd0;
        n_out.lowest_dropped = 1'b0;
        n_out.now_empty      = w_head_empty;
        if (r_op == OP_RAISE) begin
            priority if (w_bad) begin
                n_out.status = ST_BAD_VEC;
            end else if (r_c == '0) begin
                n_out.status = ST_FULL;
            end else begin
                n_out.lowest_dropped = (w_vec[TABLE_DEPTH-1] != 8'd0);
                n_out.now_empty      = 1'b0;
            end
        end else begin
            if (w_head_empty) begin
                n_out.status    = ST_TAKE_NONE;
                n_out.now_empty = 1'b1;
            end else begin
                n_out.taken_vector   = w_vec[0];
                n_out.taken_priority = w_pri[0];
                n_out.now_empty      = (w_vec[1] == 8'd0);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_op  <= i_in_word.op;
            r_vec <= i_in_word.req_vector;
            r_pri <= i_in_word.req_priority;
        end
        if (r_state == S_POS) begin
            r_c <= n_c;
        end
        if (w_go) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire
